[sv/bgmt_pkg.sv]
// Shared types, codes and constants of the boost group maximum tracker.
package bgmt_pkg;

  localparam int DEF_NUM_GROUPS      = 6;
  localparam int DEF_TASK_COUNT_BITS = 16;

  localparam int GROUP_W = 3;
  localparam int BOOST_W = 7;
  localparam int STAMP_W = 64;
  localparam int HOLD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int REQ_W   = 3;

  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 32'd50000000;
  localparam logic [BOOST_W-1:0] BOOST_LIMIT = 7'd100;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_SET_BOOST = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ENQUEUE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CREATE    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BOOST = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_HOLD_TIME = 1'b0;
  localparam logic CFG_HOLD_ALL  = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0]  max_boost_stamp;
    logic [BOOST_W-1:0]  max_boost;
    logic [GROUP_W-1:0]  new_group;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

[sv/boost_group_max_tracker.sv]
// Top level of the boost group maximum tracker: config, slot memory, sequencer, output stage.
//
// The block keeps a table of NUM_GROUPS boost groups in a single-port-read synchronous
// memory and reports, after every request item, the largest boost among the active groups
// together with its stamp. Items are handled one at a time. A request that needs no
// recompute is handled in the accept cycle, which issues the memory read of the addressed
// slot, then in the next cycle, which modifies and writes it back, and then in the output
// state, which hands the result to the output register. A recompute of the maximum reads
// every slot through the one memory read port, one slot per cycle, in a scan state that
// lies between the modify state and the output state. The output
// register holds a finished result while the next item is accepted. Slot memory entries read
// as zero until first written, so no clearing pass follows reset. Configuration writes take
// effect at the next clock edge and are meant to be made while the block is idle.
module boost_group_max_tracker #(
  parameter int NUM_GROUPS      = bgmt_pkg::DEF_NUM_GROUPS,
  parameter int TASK_COUNT_BITS = bgmt_pkg::DEF_TASK_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Bits from the lowest: group_index[2:0], boost_value[10:3], task_is_rt[11],
  // now_ns[75:12], zero fill [79:76].
  input  logic [79:0]                    in_tdata,
  // Bits from the lowest: req_type[2:0].
  input  logic [bgmt_pkg::REQ_W-1:0]     in_tuser,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Bits from the lowest: status[1:0], new_group[4:2], max_boost[11:5],
  // max_boost_stamp[75:12], zero fill [79:76].
  output logic [79:0]                    out_tdata,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [bgmt_pkg::HOLD_W-1:0]    cfg_wdata
);
  import bgmt_pkg::*;

  localparam int AW     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int WORD_W = STAMP_W + TASK_COUNT_BITS + BOOST_W;

  logic [HOLD_W-1:0] hold_time_r;
  logic              hold_all_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              res_valid;
  logic              res_ready;
  res_t              res;

  logic              out_valid_r;
  res_t              out_res_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= HOLD_RESET;
      hold_all_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HOLD_TIME: hold_time_r <= cfg_wdata;
        CFG_HOLD_ALL:  hold_all_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Each memory word holds one slot: boost in the low bits, then the task count,
  // then the stamp of the last qualifying enqueue.
  bgmt_slot_ram #(
    .DEPTH (NUM_GROUPS),
    .WIDTH (WORD_W),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgmt_seq #(
    .NUM_GROUPS      (NUM_GROUPS),
    .TASK_COUNT_BITS (TASK_COUNT_BITS),
    .AW              (AW),
    .WORD_W          (WORD_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (in_tuser),
    .group_index  (in_tdata[2:0]),
    .boost_value  (in_tdata[10:3]),
    .task_is_rt   (in_tdata[11]),
    .now_ns       (in_tdata[75:12]),
    .hold_time_ns (hold_time_r),
    .hold_all     (hold_all_r),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: a result moves in whenever the register is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

endmodule

[sv/bgmt_slot_ram.sv]
// Group slot memory: one write port, one registered read port, per-entry written bits.
module bgmt_slot_ram #(
  parameter int DEPTH = 6,
  parameter int WIDTH = 87,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [WIDTH-1:0] rdata_r;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (we) begin
      written_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (written_r[raddr]) begin
      rdata_r <= mem[raddr];
    end else begin
      rdata_r <= '0;
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/bgmt_seq.sv]
// Request sequencer: read-modify-write of one slot and the recompute scan.
module bgmt_seq #(
  parameter int NUM_GROUPS      = 6,
  parameter int TASK_COUNT_BITS = 16,
  parameter int AW              = 3,
  parameter int WORD_W          = 87
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bgmt_pkg::REQ_W-1:0]    req_type,
  input  logic [bgmt_pkg::GROUP_W-1:0]  group_index,
  input  logic [7:0]                    boost_value,
  input  logic                          task_is_rt,
  input  logic [bgmt_pkg::STAMP_W-1:0]  now_ns,
  input  logic [bgmt_pkg::HOLD_W-1:0]   hold_time_ns,
  input  logic                          hold_all,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [WORD_W-1:0]             ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [WORD_W-1:0]             ram_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bgmt_pkg::res_t                res
);
  import bgmt_pkg::*;

  localparam int PTR_W = $clog2(NUM_GROUPS + 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_GROUPS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_GROUPS - 1);
  localparam logic [TASK_COUNT_BITS-1:0] TASK_MAX = {TASK_COUNT_BITS{1'b1}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [REQ_W-1:0]      req_r;
  logic [GROUP_W-1:0]    g_r;
  logic [7:0]            boost_r;
  logic                  rt_r;
  logic [STAMP_W-1:0]    now_r;
  logic [AW-1:0]         addr_r;
  logic                  free_found_r;
  logic [NUM_GROUPS-1:0] taken_r, taken_nxt;
  logic [BOOST_W-1:0]    top_boost_r, top_boost_nxt;
  logic [STAMP_W-1:0]    top_stamp_r, top_stamp_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [GROUP_W-1:0]    created_r, created_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic                  ev_valid_r;
  logic [AW-1:0]         ev_idx_r;
  logic [BOOST_W-1:0]    best_r, best_nxt;
  logic [STAMP_W-1:0]    ts_r, ts_nxt;

  logic                  accept;
  logic                  free_found;
  logic [AW-1:0]         free_idx;
  logic [BOOST_W-1:0]    cur_boost;
  logic [TASK_COUNT_BITS-1:0] cur_tasks;
  logic [STAMP_W-1:0]    cur_stamp;
  logic [STAMP_W-1:0]    age;
  logic                  active;
  logic                  in_range;
  logic                  addressed;
  logic                  bad_index;
  logic [BOOST_W-1:0]    new_boost;
  logic [TASK_COUNT_BITS-1:0] new_tasks;
  logic [STAMP_W-1:0]    new_stamp;
  logic                  recompute;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Lowest free slot from 1 upward.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = NUM_GROUPS - 1; s >= 1; s--) begin
      if (!taken_r[s]) begin
        free_found = 1'b1;
        free_idx   = AW'(s);
      end
    end
  end

  // Fields of the word that the memory returns this cycle.
  assign cur_boost = ram_rdata[BOOST_W-1:0];
  assign cur_tasks = ram_rdata[BOOST_W +: TASK_COUNT_BITS];
  assign cur_stamp = ram_rdata[BOOST_W+TASK_COUNT_BITS +: STAMP_W];
  assign age       = now_r - cur_stamp;
  assign active    = (cur_tasks != '0) || (age <= {{(STAMP_W-HOLD_W){1'b0}}, hold_time_ns});

  assign in_range  = ({1'b0, g_r} < (GROUP_W+1)'(NUM_GROUPS));
  assign addressed = (req_r == REQ_SET_BOOST) || (req_r == REQ_ENQUEUE) ||
                     (req_r == REQ_DEQUEUE) || (req_r == REQ_RELEASE);
  assign bad_index = addressed &&
                     (!in_range || !taken_r[addr_r] ||
                      ((req_r == REQ_RELEASE) && (g_r == '0)));

  always_comb begin
    ram_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (req_type == REQ_CREATE) begin
          ram_raddr = free_idx;
        end else begin
          ram_raddr = group_index[AW-1:0];
        end
      end
      S_SCAN:  ram_raddr = rd_ptr_r[AW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    taken_nxt     = taken_r;
    top_boost_nxt = top_boost_r;
    top_stamp_nxt = top_stamp_r;
    status_nxt    = status_r;
    created_nxt   = created_r;
    rd_ptr_nxt    = rd_ptr_r;
    best_nxt      = best_r;
    ts_nxt        = ts_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    new_boost     = cur_boost;
    new_tasks     = cur_tasks;
    new_stamp     = cur_stamp;
    recompute     = 1'b0;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_MOD;
          status_nxt  = ST_OK;
          created_nxt = '0;
        end
      end

      S_MOD: begin
        if (bad_index) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          case (req_r)
            REQ_SET_BOOST: begin
              if (boost_r[7] || (boost_r[6:0] > BOOST_LIMIT)) begin
                status_nxt = ST_BAD_BOOST;
              end else begin
                new_boost = boost_r[6:0];
                ram_we    = 1'b1;
                if ((new_boost > top_boost_r) && active) begin
                  top_boost_nxt = new_boost;
                  top_stamp_nxt = cur_stamp;
                end else if ((top_boost_r == cur_boost) && (cur_boost > new_boost)) begin
                  recompute = 1'b1;
                end
              end
            end
            REQ_ENQUEUE: begin
              if (cur_tasks != TASK_MAX) begin
                new_tasks = cur_tasks + TASK_COUNT_BITS'(1);
              end
              if (hold_all || rt_r) begin
                new_stamp = now_r;
              end
              ram_we    = 1'b1;
              recompute = (new_tasks == TASK_COUNT_BITS'(1));
            end
            REQ_DEQUEUE: begin
              if (cur_tasks != '0) begin
                new_tasks = cur_tasks - TASK_COUNT_BITS'(1);
              end
              ram_we = 1'b1;
            end
            REQ_CREATE: begin
              if (free_found_r) begin
                taken_nxt[addr_r] = 1'b1;
                new_boost   = '0;
                new_stamp   = '0;
                ram_we      = 1'b1;
                created_nxt = GROUP_W'(addr_r);
              end else begin
                status_nxt = ST_NO_FREE;
              end
            end
            REQ_RELEASE: begin
              taken_nxt[addr_r] = 1'b0;
              new_boost = '0;
              ram_we    = 1'b1;
            end
            default: begin
            end
          endcase
        end
        rd_ptr_nxt = '0;
        state_nxt  = recompute ? S_SCAN : S_OUT;
      end

      S_SCAN: begin
        if (rd_ptr_r != PTR_END) begin
          rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
        end
        if (ev_valid_r) begin
          if (ev_idx_r == '0) begin
            best_nxt = cur_boost;
            ts_nxt   = now_r;
          end else if (taken_r[ev_idx_r] && active && (cur_boost >= best_r)) begin
            best_nxt = cur_boost;
            ts_nxt   = cur_stamp;
          end
          if (ev_idx_r == LAST_IDX) begin
            top_boost_nxt = best_nxt;
            top_stamp_nxt = ts_nxt;
            state_nxt     = S_OUT;
          end
        end
      end

      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    ram_wdata = {new_stamp, new_tasks, new_boost};
  end

  assign res.status          = status_r;
  assign res.new_group       = created_r;
  assign res.max_boost       = top_boost_r;
  assign res.max_boost_stamp = top_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taken_r     <= NUM_GROUPS'(1);
      top_boost_r <= '0;
      top_stamp_r <= '0;
      ev_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      top_boost_r <= top_boost_nxt;
      top_stamp_r <= top_stamp_nxt;
      ev_valid_r  <= (state_r == S_SCAN) && (rd_ptr_r != PTR_END);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= req_type;
      g_r          <= group_index;
      boost_r      <= boost_value;
      rt_r         <= task_is_rt;
      now_r        <= now_ns;
      addr_r       <= ram_raddr;
      free_found_r <= free_found;
    end
    status_r  <= status_nxt;
    created_r <= created_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    ev_idx_r  <= rd_ptr_r[AW-1:0];
    best_r    <= best_nxt;
    ts_r      <= ts_nxt;
  end

endmodule
